/* rtl/core/ludpp_pkg.sv */
// Shared types, sizes and arithmetic helpers for the LU decomposition block.
// Used by every module under rtl/core; depends on nothing.
package ludpp_pkg;

  localparam int DIM      = 4;
  localparam int IW       = $clog2(DIM);
  localparam int NSQ      = DIM * DIM;
  localparam int SQW      = $clog2(NSQ);
  localparam int NRES     = 2 * NSQ + DIM;
  localparam int EW       = $clog2(NRES);
  localparam int ACC_W    = 56;
  localparam int CFG_W    = 31;
  localparam int DIV_NUMW = 48;

  typedef enum logic [1:0] {
    KIND_LOWER = 2'd0,
    KIND_UPPER = 2'd1,
    KIND_PERM  = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [31:0] element_value;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] result_value;
    logic               last_result;
  } out_item_t;

  typedef logic [NSQ-1:0][31:0] mat_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_CHK, B_MUL, B_ACC, B_CDIFF, B_SWAP, B_UDIFF,
    B_PIV, B_DSTART, B_DWAIT, B_NEXTK, B_EMIT
  } back_state_t;

  // Unsigned magnitude; the most negative value maps to 2^31.
  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    logic [31:0] r;
    r = x[31] ? 32'(-x) : 32'(x);
    return r;
  endfunction

  // Saturate a wide signed difference to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W:0] x);
    logic signed [31:0] r;
    if (x > $signed({{(ACC_W-30){1'b0}}, 31'h7FFFFFFF})) r = 32'sh7FFFFFFF;
    else if (x < $signed({{(ACC_W-30){1'b1}}, 31'h0})) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/ludpp_front.sv */
// Input side: stores incoming elements in row-major order and hands a full
// matrix snapshot to the command queue at the last element. Uses ludpp_pkg.
module ludpp_front import ludpp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t element,
  output logic     q_push,
  output mat_t     q_matrix
);

  mat_t           work_matrix;
  logic [SQW-1:0] load_count;

  // Merge the arriving element into the snapshot
  always_comb begin
    q_matrix = work_matrix;
    q_matrix[load_count] = element.element_value;
    q_push = accept && element.last_element;
  end

  // Store element and advance the load position
  always_ff @(posedge clk) begin
    if (accept) work_matrix[load_count] <= element.element_value;
    if (rst) begin
      load_count <= '0;
    end else if (accept) begin
      if (element.last_element || load_count == SQW'(NSQ-1)) load_count <= '0;
      else load_count <= load_count + 1'b1;
    end
  end

endmodule

/* rtl/core/ludpp_queue.sv */
// Single-entry matrix queue between front and back, so each side can stall
// on its own. Uses ludpp_pkg.
module ludpp_queue import ludpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  mat_t push_matrix,
  input  logic pop,
  output logic valid,
  output mat_t matrix
);

  // Hold one pending matrix until the back end takes it
  always_ff @(posedge clk) begin
    if (push) matrix <= push_matrix;
    if (rst) valid <= 1'b0;
    else if (push) valid <= 1'b1;
    else if (pop) valid <= 1'b0;
  end

endmodule

/* rtl/core/ludpp_div.sv */
// Restoring divider, one quotient bit per cycle: (dividend * 2^16) / divisor,
// truncated toward zero and saturated to 32 bits. Uses ludpp_pkg.
module ludpp_div import ludpp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_NUMW + 1);

  logic [DIV_NUMW-1:0] num;
  logic [DIV_NUMW-1:0] quo;
  logic [31:0]         den;
  logic [31:0]         rem;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                neg;
  logic [32:0]         rem_sh;
  logic                fits;
  logic                done;
  logic signed [31:0]  quotient;

  assign rem_sh = {rem, num[DIV_NUMW-1]};
  assign fits   = rem_sh >= {1'b0, den};

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= {mag32(req.dividend), 16'h0};
      den <= mag32(req.divisor);
      neg <= req.dividend[31] ^ req.divisor[31];
      rem <= '0;
      quo <= '0;
      cnt <= CW'(DIV_NUMW);
    end else if (busy) begin
      num <= {num[DIV_NUMW-2:0], 1'b0};
      quo <= {quo[DIV_NUMW-2:0], fits};
      rem <= fits ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
      cnt <= cnt - 1'b1;
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && cnt == CW'(1);
      if (req.start) busy <= 1'b1;
      else if (busy && cnt == CW'(1)) busy <= 1'b0;
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (!neg) begin
      quotient = (quo > DIV_NUMW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo[31:0];
    end else begin
      quotient = (quo > DIV_NUMW'(33'h80000000)) ? 32'sh80000000 : 32'(-quo[31:0]);
    end
  end

  assign rsp = '{done: done, quotient: quotient};

endmodule

/* rtl/core/ludpp_back.sv */
// Back end: sequences the pivoted Doolittle elimination with one shared
// multiplier and the iterative divider, then streams L, U and the
// permutation through an output register. Uses ludpp_pkg, ludpp_div.
module ludpp_back import ludpp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] min_pivot,
  input  logic             q_valid,
  input  mat_t             q_matrix,
  output logic             q_pop,
  input  logic             pop,
  output logic             out_valid,
  output out_item_t        out_data
);

  back_state_t state, state_next;

  logic signed [31:0] a_m [NSQ];
  logic signed [31:0] l_m [NSQ];
  logic signed [31:0] u_m [NSQ];
  logic signed [31:0] cand [DIM];
  logic [IW-1:0]      order [DIM];
  logic [IW-1:0]      k, i, j, p, best;
  logic               urow;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic [EW-1:0]      e;
  logic               load_out;

  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [IW-1:0]      mrow, mcol;
  logic signed [63:0] prod_rnd;
  logic signed [ACC_W:0] diff;
  logic signed [31:0] diff_sat;
  logic [SQW-1:0]     e_idx;
  out_item_t          item;

  ludpp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign mrow     = urow ? k : i;
  assign mcol     = urow ? j : k;
  assign prod_rnd = (prod + 64'sd32768) >>> 16;
  assign diff     = {a_m[{mrow, mcol}][31], {(ACC_W-32){a_m[{mrow, mcol}][31]}},
                     a_m[{mrow, mcol}]} - {acc[ACC_W-1], acc};
  assign diff_sat = sat32(diff);
  assign load_out = state == B_EMIT && (!out_valid || pop);
  assign e_idx    = e[SQW-1:0];

  assign dreq = '{start: state == B_DSTART, dividend: cand[i], divisor: cand[k]};

  // Build the result item for the emit position
  always_comb begin
    item = '0;
    if (e < EW'(NSQ)) begin
      item.result_kind  = KIND_LOWER;
      item.row_index    = 2'(e_idx[SQW-1:IW]);
      item.col_index    = 2'(e_idx[IW-1:0]);
      item.result_value = l_m[e_idx];
    end else if (e < EW'(2*NSQ)) begin
      item.result_kind  = KIND_UPPER;
      item.row_index    = 2'(e_idx[SQW-1:IW]);
      item.col_index    = 2'(e_idx[IW-1:0]);
      item.result_value = u_m[e_idx];
    end else begin
      item.result_kind  = KIND_PERM;
      item.col_index    = 2'(e[IW-1:0]);
      item.result_value = 32'(order[e[IW-1:0]]);
      item.last_result  = e == EW'(NRES-1);
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = B_CHK;
        end
      end
      B_CHK:   state_next = (p == k) ? (urow ? B_UDIFF : B_CDIFF) : B_MUL;
      B_MUL:   state_next = B_ACC;
      B_ACC:   state_next = B_CHK;
      B_CDIFF: state_next = (i == IW'(DIM-1)) ? B_SWAP : B_CHK;
      B_SWAP:  state_next = (k == IW'(DIM-1)) ? B_PIV : B_CHK;
      B_UDIFF: state_next = (j == IW'(DIM-1)) ? B_PIV : B_CHK;
      B_PIV: begin
        if (k != IW'(DIM-1) && mag32(cand[k]) > {1'b0, min_pivot}) state_next = B_DSTART;
        else state_next = B_NEXTK;
      end
      B_DSTART: state_next = B_DWAIT;
      B_DWAIT: begin
        if (drsp.done) state_next = (i == IW'(DIM-1)) ? B_NEXTK : B_DSTART;
      end
      B_NEXTK: state_next = (k == IW'(DIM-1)) ? B_EMIT : B_CHK;
      B_EMIT:  if (load_out && e == EW'(NRES-1)) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          for (int n = 0; n < NSQ; n++) begin
            a_m[n] <= q_matrix[n];
            l_m[n] <= (n / DIM == n % DIM) ? 32'sh00010000 : 32'sh0;
            u_m[n] <= 32'sh0;
          end
          for (int r = 0; r < DIM; r++) order[r] <= IW'(r);
          k <= '0; i <= '0; p <= '0; urow <= 1'b0;
          acc <= '0;
        end
      end
      B_MUL: prod <= l_m[{mrow, p}] * u_m[{p, mcol}];
      B_ACC: begin
        acc <= acc + ACC_W'(prod_rnd);
        p <= p + 1'b1;
      end
      B_CDIFF: begin
        cand[i] <= diff_sat;
        if (i == k || mag32(diff_sat) > mag32(cand[best])) best <= i;
        i <= i + 1'b1;
        p <= '0;
        acc <= '0;
      end
      B_SWAP: begin
        // Swap rows k and best of the working copy, computed L and order
        if (best != k) begin
          for (int c = 0; c < DIM; c++) begin
            a_m[{k, IW'(c)}]    <= a_m[{best, IW'(c)}];
            a_m[{best, IW'(c)}] <= a_m[{k, IW'(c)}];
            if (IW'(c) < k) begin
              l_m[{k, IW'(c)}]    <= l_m[{best, IW'(c)}];
              l_m[{best, IW'(c)}] <= l_m[{k, IW'(c)}];
            end
          end
          cand[k]     <= cand[best];
          cand[best]  <= cand[k];
          order[k]    <= order[best];
          order[best] <= order[k];
          u_m[{k, k}] <= cand[best];
        end else begin
          u_m[{k, k}] <= cand[k];
        end
        j <= k + 1'b1;
        p <= '0;
        acc <= '0;
        urow <= 1'b1;
      end
      B_UDIFF: begin
        u_m[{k, j}] <= diff_sat;
        j <= j + 1'b1;
        p <= '0;
        acc <= '0;
      end
      B_PIV: i <= k + 1'b1;
      B_DWAIT: begin
        if (drsp.done) begin
          l_m[{i, k}] <= drsp.quotient;
          i <= i + 1'b1;
        end
      end
      B_NEXTK: begin
        k <= k + 1'b1;
        i <= k + 1'b1;
        p <= '0;
        acc <= '0;
        urow <= 1'b0;
      end
      default: ;
    endcase
  end

  // Output register and emit counter
  always_ff @(posedge clk) begin
    if (load_out) out_data <= item;
    if (rst) begin
      out_valid <= 1'b0;
      e <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        e <= (e == EW'(NRES-1)) ? '0 : e + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/lu_decompose_partial_pivot.sv */
// LU decomposition with partial pivoting of a 4x4 Q16.16 matrix.
//
// Input channel: element carries one matrix element per transfer in
// row-major order; a transfer happens when push is high and full is low.
// The element with last_element set starts the decomposition.
// Result channel: the oldest result sits on result while empty is low and
// is transferred when pop is high. A decomposition yields 36 results: all of
// L, then all of U (row-major), then the permutation, the last flagged.
// Configuration: cfg_we writes cfg_data into the pivot threshold at once.
//
// Elements load at one per cycle while full is low. The elimination runs on
// one shared multiplier, each product passing check, multiply and accumulate
// states, and a bit-serial divider; then results stream at one per cycle
// while pop stays high. One further matrix may load while one is processed;
// full rises while it waits. A stalled receiver holds the result register
// and the back end pauses in emission. Reset empties both sides, returns
// the load position to zero and sets the threshold to 1.
module lu_decompose_partial_pivot import ludpp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         element,
  output logic             empty,
  input  logic             pop,
  output out_item_t        result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] min_pivot;
  logic             q_push, q_pop, q_valid, out_valid;
  mat_t             push_matrix, q_matrix;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) min_pivot <= CFG_W'(1);
    else if (cfg_we) min_pivot <= cfg_data;
  end

  assign full  = q_valid;
  assign empty = !out_valid;

  ludpp_front u_front (
    .clk(clk), .rst(rst), .accept(push && !full), .element(element),
    .q_push(q_push), .q_matrix(push_matrix)
  );

  ludpp_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_matrix(push_matrix),
    .pop(q_pop), .valid(q_valid), .matrix(q_matrix)
  );

  ludpp_back u_back (
    .clk(clk), .rst(rst), .min_pivot(min_pivot), .q_valid(q_valid),
    .q_matrix(q_matrix), .q_pop(q_pop), .pop(pop), .out_valid(out_valid),
    .out_data(result)
  );

endmodule

/* rtl/core/ludpp_checker.sv */
// Port-level checks for the LU decomposition block, bound to the top level.
// Uses ludpp_pkg.
module ludpp_checker import ludpp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  // Nothing to take straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("stalled result changed");

  // Permutation entries carry row zero
  a_perm_row: assert property (@(posedge clk) disable iff (rst)
    !empty && result.result_kind == KIND_PERM |-> result.row_index == 2'd0)
    else $error("permutation entry with nonzero row");

  // Final flag only on the last permutation position
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.last_result |->
      result.result_kind == KIND_PERM && result.col_index == 2'(DIM-1))
    else $error("final flag on wrong entry");

endmodule

bind lu_decompose_partial_pivot ludpp_checker u_ludpp_checker (
  .clk(clk), .rst(rst), .empty(empty), .pop(pop), .result(result)
);

/* test/tb_lu_decompose_partial_pivot.sv */
// Testbench for lu_decompose_partial_pivot: streams Q16.16 matrices in, predicts the
// lower and upper factors and the row permutation, and checks every result in order.
// Depends on ludpp_pkg and the lu_decompose_partial_pivot module.
`timescale 1ns / 100ps

module tb_lu_decompose_partial_pivot;
  import ludpp_pkg::*;

  localparam int N = 4;
  localparam int NN = N * N;
  localparam int ONE = 32'sh0001_0000;
  localparam logic [CFG_W-1:0] THRESH_MAX = 31'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  in_item_t element = '0;
  logic full;
  logic empty;
  out_item_t result;

  // Predictor state
  int signed matrix_store[NN];
  int signed lower_m[NN];
  int signed upper_m[NN];
  int unsigned perm[N];
  int unsigned load_pos;
  logic [CFG_W-1:0] pivot_floor;
  out_item_t factor_queue[$];

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned matrices_sent = 0;
  int unsigned elements_sent = 0;
  bit quiet = 1'b0;
  int unsigned pop_hold = 0;

  lu_decompose_partial_pivot u_dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .element  (element),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Q16.16 product, rounded to nearest with ties upward
  function automatic longint q16_product(int signed a, int signed b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int signed clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic longint magnitude(int signed x);
    return (x < 0) ? -longint'(x) : longint'(x);
  endfunction

  // Factorise the stored matrix and queue the 36 expected results
  task automatic predict_factors();
    int signed a[NN];
    int signed cand[N];
    int signed t;
    int unsigned u;
    int best;
    longint s;
    out_item_t r;
    a = matrix_store;
    for (int i = 0; i < N; i++) begin
      perm[i] = i;
      for (int j = 0; j < N; j++) begin
        lower_m[i*N+j] = (i == j) ? ONE : 0;
        upper_m[i*N+j] = 0;
      end
    end
    for (int k = 0; k < N; k++) begin
      best = k;
      for (int i = k; i < N; i++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += q16_product(lower_m[i*N+p], upper_m[p*N+k]);
        cand[i] = clamp32(longint'(a[i*N+k]) - s);
        if (magnitude(cand[i]) > magnitude(cand[best])) best = i;
      end
      // swap working rows, computed lower entries and the permutation together
      if (best != k) begin
        for (int j = 0; j < N; j++) begin
          t = a[k*N+j]; a[k*N+j] = a[best*N+j]; a[best*N+j] = t;
        end
        for (int p = 0; p < k; p++) begin
          t = lower_m[k*N+p]; lower_m[k*N+p] = lower_m[best*N+p]; lower_m[best*N+p] = t;
        end
        t = cand[k]; cand[k] = cand[best]; cand[best] = t;
        u = perm[k]; perm[k] = perm[best]; perm[best] = u;
      end
      upper_m[k*N+k] = cand[k];
      for (int j = k + 1; j < N; j++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += q16_product(lower_m[k*N+p], upper_m[p*N+j]);
        upper_m[k*N+j] = clamp32(longint'(a[k*N+j]) - s);
      end
      // leave the column at zero when the pivot is too small
      if (magnitude(cand[k]) > longint'(pivot_floor)) begin
        for (int i = k + 1; i < N; i++)
          lower_m[i*N+k] = clamp32((longint'(cand[i]) * 65536) / longint'(cand[k]));
      end
    end
    for (int m = 0; m < 2; m++)
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          r.result_kind = (m == 0) ? KIND_LOWER : KIND_UPPER;
          r.row_index = 2'(i);
          r.col_index = 2'(j);
          r.result_value = (m == 0) ? lower_m[i*N+j] : upper_m[i*N+j];
          r.last_result = 1'b0;
          factor_queue.push_back(r);
        end
    for (int i = 0; i < N; i++) begin
      r.result_kind = KIND_PERM;
      r.row_index = '0;
      r.col_index = 2'(i);
      r.result_value = perm[i];
      r.last_result = (i == N - 1);
      factor_queue.push_back(r);
    end
  endtask

  // Transfer one element; called just after a rising edge, returns at the accepting edge
  task automatic send_element(int signed value, bit last);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    push <= 1'b1;
    element <= '{element_value: value, last_element: last};
    do @(posedge clk); while (full);
    elements_sent++;
    matrix_store[load_pos] = value;
    if (last) begin
      load_pos = 0;
      matrices_sent++;
      predict_factors();
    end else begin
      load_pos = (load_pos + 1) % NN;
    end
  endtask

  task automatic release_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  // Send count elements of m, cycling through it, flagging the last one
  task automatic send_matrix(int signed m[NN], int count);
    for (int i = 0; i < count; i++) send_element(m[i % NN], i == count - 1);
    release_push();
  endtask

  task automatic drain();
    while (factor_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_pivot_floor(logic [CFG_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    pivot_floor = value;
  endtask

  function automatic int signed random_element();
    case ($urandom_range(0, 9))
      0: return int'($urandom);
      1: case ($urandom_range(0, 4))
           0: return 32'sh7FFF_FFFF;
           1: return 32'sh8000_0000;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  task automatic test_identity();
    int signed m[NN];
    for (int i = 0; i < NN; i++) m[i] = (i % (N + 1) == 0) ? ONE : 0;
    send_matrix(m, NN);
  endtask

  // Zero leading entry forces a swap; rows 1 and 2 tie in magnitude, the first of them (row 1) wins
  task automatic test_pivot_tie();
    int signed m[NN];
    m = '{0, 2*ONE, 3*ONE, ONE,
          3*ONE, ONE, 0, -ONE,
          -3*ONE, 5*ONE, ONE, 2*ONE,
          ONE, -ONE, 4*ONE, 7*ONE};
    send_matrix(m, NN);
  endtask

  // Singular matrices under a zero floor: zero pivots are not above it
  task automatic test_zero_pivots();
    int signed m[NN];
    set_pivot_floor('0);
    for (int i = 0; i < NN; i++) m[i] = 0;
    send_matrix(m, NN);
    for (int i = 0; i < NN; i++) m[i] = (i < N) ? ONE : 2 * ONE;
    send_matrix(m, NN);
  endtask

  // Full-scale values drive sums and quotients into saturation
  task automatic test_extremes();
    int signed m[NN];
    m = '{2, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
          1, 32'sh8000_0000, 32'sh7FFF_FFFF, -1,
          -1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh8000_0000, 3, -2, 32'sh7FFF_FFFF};
    send_matrix(m, NN);
    for (int i = 0; i < NN; i++) m[i] = (i % 3 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    send_matrix(m, NN);
  endtask

  // Highest floor keeps every lower column at zero unless a pivot is the most negative value
  task automatic test_floor_max();
    int signed m[NN];
    set_pivot_floor(THRESH_MAX);
    for (int i = 0; i < NN; i++) m[i] = random_element();
    send_matrix(m, NN);
    set_pivot_floor(31'd1);
  endtask

  // Early last element reuses old entries; a long run wraps the load position
  task automatic test_short_and_wrap();
    int signed m[NN];
    for (int i = 0; i < NN; i++) m[i] = random_element();
    send_matrix(m, 5);
    send_matrix(m, NN + 5);
  endtask

  task automatic test_random(int unsigned target);
    int signed m[NN];
    int count;
    while (elements_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_pivot_floor('0);
          1: set_pivot_floor(31'd1);
          2: set_pivot_floor(31'($urandom_range(0, 4 * ONE)));
          default: set_pivot_floor(31'($urandom));
        endcase
      end
      if (elements_sent > target - 70) quiet = 1'b1;
      for (int i = 0; i < NN; i++) m[i] = random_element();
      case ($urandom_range(0, 9))
        0: count = $urandom_range(1, NN - 1);
        1: count = $urandom_range(NN + 1, NN + 6);
        default: count = NN;
      endcase
      send_matrix(m, count);
    end
  endtask

  // Receiver: stall in random bursts, none in the quiet part
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (quiet) begin
      pop <= 1'b1;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if ($urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(0, 17);
    end else begin
      pop <= 1'b1;
    end
  end

  // Check each transferred result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (factor_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %p", $time, result);
      end else begin
        want = factor_queue.pop_front();
        if (result.result_kind !== want.result_kind || result.row_index !== want.row_index ||
            result.col_index !== want.col_index ||
            result.result_value !== want.result_value ||
            result.last_result !== want.last_result) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, result);
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    load_pos = 0;
    pivot_floor = 31'd1;
    for (int i = 0; i < NN; i++) matrix_store[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_pivot_tie();
    test_zero_pivots();
    test_extremes();
    test_floor_max();
    test_short_and_wrap();
    test_random(330);
    drain();
    if (factor_queue.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, factor_queue.size());
    end
    $display("Covered %0d elements in %0d decompositions, %0d results checked, %0d errors.",
             elements_sent, matrices_sent, results_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
